// File: rtl/aes128_block_cipher_core_macros.svh
// ---------------------------------------------------------------------------
// AES-128 core assertion macros
// Shared concurrent assertion forms for the cipher core.
// ---------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_CORE_MACROS_SVH
`define AES128_BLOCK_CIPHER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/aes_pkg.sv
// ---------------------------------------------------------------------------
// AES-128 package
// Shared types, byte tables and GF(2^8) helpers for the cipher core.
// ---------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned RoundW    = 4;
    localparam int unsigned RkWords   = 44;
    localparam int unsigned RkAddrW   = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

    // controller to datapath
    typedef struct packed {
        logic               load;      // capture block and start key expansion
        logic               key_step;  // produce one round-key group
        logic               first;     // initial AddRoundKey
        logic               round;     // one full or final round
        logic               last;      // final round: no MixColumns
        logic [RoundW-1:0]  rnd;       // round index
    } dp_cmd_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // inverse mix: premultiply by {05,00,04,00} then forward mix
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

endpackage

// File: rtl/aes_ctrl.sv
// ---------------------------------------------------------------------------
// AES-128 controller
// Sequences key expansion and the ten rounds for one block.
// ---------------------------------------------------------------------------
`include "aes128_block_cipher_core_macros.svh"
module aes_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             decrypt,
    output logic             busy,
    output logic             done,
    output logic             dir,
    output aes_pkg::dp_cmd_t cmd
);
    import aes_pkg::*;

    state_t              state_reg, state_next;
    logic [RoundW-1:0]   cnt_reg, cnt_next;
    logic                dir_reg, dir_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dir_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dir_reg   <= dir_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dir_next   = dir_reg;
        cmd        = '0;
        cmd.rnd    = cnt_reg;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    dir_next   = decrypt;
                    cnt_next   = RoundW'(1);
                    state_next = ST_KEY;
                end
            end
            ST_KEY:
            begin
                // one round-key group per cycle, groups 1..10
                cmd.key_step = 1'b1;
                if (cnt_reg == RoundW'(NumRounds))
                begin
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
                else
                    cnt_next = cnt_reg + RoundW'(1);
            end
            ST_RUN:
            begin
                if (cnt_reg == '0)
                    cmd.first = 1'b1;
                else
                    cmd.round = 1'b1;
                cmd.last = (cnt_reg == RoundW'(NumRounds));
                if (cmd.last)
                    state_next = ST_DONE;
                else
                    cnt_next = cnt_reg + RoundW'(1);
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign dir  = dir_reg;

    `AES_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `AES_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy)
    `AES_ASSERT_IMPL(a_cmd_excl, clk, rst_n, 1'b1,
        $onehot0({cmd.load, cmd.key_step, cmd.first, cmd.round}))
endmodule

// File: rtl/aes_datapath.sv
// ---------------------------------------------------------------------------
// AES-128 datapath
// Round-key memory, key expansion step and a shared round unit.
// ---------------------------------------------------------------------------
module aes_datapath (
    input  logic             clk,
    input  logic [63:0]      key_high,
    input  logic [63:0]      key_low,
    input  logic [63:0]      block_high,
    input  logic [63:0]      block_low,
    input  logic             dir,
    input  aes_pkg::dp_cmd_t cmd,
    output logic [127:0]     state_out
);
    import aes_pkg::*;

    // round keys as 11 rows of 128 bits; read at one address per cycle
    logic [127:0]        rk_mem [NumRounds+1];
    logic [127:0]        rk_prev_reg, rk_prev_next;
    logic [7:0]          rcon_reg, rcon_next;
    logic [127:0]        st_reg, st_next;
    logic [127:0]        rk_rd;
    logic [RoundW-1:0]   rk_addr;
    logic [127:0]        rk_new;
    logic [31:0]         tw, w0, w1, w2, w3;
    logic [127:0]        s_sub, s_shf, s_mix, s_ark;
    logic [127:0]        d_shf, d_sub, d_ark, d_mix;

    // next round-key group
    always_comb
    begin
        tw = rk_prev_reg[31:0];
        tw = {sbox(tw[23:16]), sbox(tw[15:8]), sbox(tw[7:0]), sbox(tw[31:24])}
             ^ {rcon_reg, 24'h0};
        w0 = rk_prev_reg[127:96] ^ tw;
        w1 = rk_prev_reg[95:64] ^ w0;
        w2 = rk_prev_reg[63:32] ^ w1;
        w3 = rk_prev_reg[31:0] ^ w2;
        rk_new = {w0, w1, w2, w3};
    end

    always_comb
    begin
        rk_prev_next = rk_prev_reg;
        rcon_next    = rcon_reg;
        if (cmd.load)
        begin
            rk_prev_next = {key_high, key_low};
            rcon_next    = 8'h01;
        end
        else if (cmd.key_step)
        begin
            rk_prev_next = rk_new;
            rcon_next    = xtime(rcon_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        rk_prev_reg <= rk_prev_next;
        rcon_reg    <= rcon_next;
        st_reg      <= st_next;
        if (cmd.load)
            rk_mem[0] <= {key_high, key_low};
        else if (cmd.key_step)
            rk_mem[cmd.rnd] <= rk_new;
    end

    // the key for the current round is read combinationally from a small register file
    assign rk_addr = dir ? RoundW'(NumRounds) - cmd.rnd : cmd.rnd;
    assign rk_rd   = rk_mem[rk_addr];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s_sub[127-8*i -: 8] = sbox(st_reg[127-8*i -: 8]);
            d_sub[127-8*i -: 8] = inv_sbox(d_shf[127-8*i -: 8]);
        end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                s_shf[127-8*(4*c+r) -: 8] = s_sub[127-8*(4*((c+r)%4)+r) -: 8];
                d_shf[127-8*(4*c+r) -: 8] = st_reg[127-8*(4*((c+4-r)%4)+r) -: 8];
            end
        for (int c = 0; c < 4; c++)
        begin
            s_mix[127-32*c -: 32] = mix_col(s_shf[127-32*c -: 32]);
            d_mix[127-32*c -: 32] = inv_mix_col(d_ark[127-32*c -: 32]);
        end
        s_ark = (cmd.last ? s_shf : s_mix) ^ rk_rd;
        d_ark = d_sub ^ rk_rd;
    end

    always_comb
    begin
        st_next = st_reg;
        if (cmd.load)
            st_next = {block_high, block_low};
        else if (cmd.first)
            st_next = st_reg ^ rk_rd;
        else if (cmd.round)
            st_next = dir ? (cmd.last ? d_ark : d_mix) : s_ark;
    end

    assign state_out = st_reg;
endmodule

// File: rtl/aes128_block_cipher_core.sv
// ---------------------------------------------------------------------------
// AES-128 block cipher core
// Encrypts or decrypts one 128-bit block under a configured key.
// ---------------------------------------------------------------------------
// A block is taken when start is high and busy is low. Each block is taken,
// then the key is expanded one round-key group per cycle, then the initial
// key add and ten rounds run through one shared round unit, then the result
// is presented. The next block can be taken in the cycle after the result
// strobe. done is high for a single cycle when the result is presented; the
// result stays on the outputs until the next block is taken, and the receiver
// cannot stall it. Write the key only while busy is low.
module aes128_block_cipher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        decrypt,
    output logic        done,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import aes_pkg::*;

    logic [63:0]  key_high_reg, key_low_reg;
    logic         dir;
    dp_cmd_t      cmd;
    logic [127:0] st;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .decrypt (decrypt),
        .busy    (busy),
        .done    (done),
        .dir     (dir),
        .cmd     (cmd)
    );

    aes_datapath u_dp (
        .clk        (clk),
        .key_high   (key_high_reg),
        .key_low    (key_low_reg),
        .block_high (block_high),
        .block_low  (block_low),
        .dir        (dir),
        .cmd        (cmd),
        .state_out  (st)
    );

    assign result_high = st[127:64];
    assign result_low  = st[63:0];
endmodule
